// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms with a switch to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, cond, msg)

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- sv/dtf_pkg.sv -----
// ----------------------------------------------------------------------------
// Decimal text parser package
// Widths, scale limits and character codes shared by the parser and its channels.
// ----------------------------------------------------------------------------
`default_nettype none

package dtf_pkg;

   localparam int CHAR_W = 8;
   localparam int FRAC_W = 3;

   localparam logic [FRAC_W-1:0] FRAC_RESET = 3'd2;
   localparam logic [FRAC_W-1:0] MAX_FRAC   = 3'd4;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;

endpackage

`default_nettype wire

// ----- sv/dtf_channels.sv -----
// ----------------------------------------------------------------------------
// Decimal text parser channels
// Valid/ready interfaces for the character, result and scale write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtf_req_if;
   import dtf_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_in;
   logic              line_end;

   modport source (output valid, output char_in, output line_end, input ready);
   modport sink   (input valid, input char_in, input line_end, output ready);
endinterface

interface dtf_rsp_if #(
   parameter int VALUE_BITS = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] value;
   logic                         saturated;

   modport source (output valid, output value, output saturated, input ready);
   modport sink   (input valid, input value, input saturated, output ready);
endinterface

interface dtf_csr_if;
   import dtf_pkg::*;

   logic              valid;
   logic              ready;
   logic [FRAC_W-1:0] frac_digits;

   modport source (output valid, output frac_digits, input ready);
   modport sink   (input valid, input frac_digits, output ready);
endinterface

`default_nettype wire

// ----- sv/decimal_text_to_fixed_point.sv -----
// ----------------------------------------------------------------------------
// Decimal text to fixed-point parser
// Streams ASCII characters and returns each decimal number as a scaled integer.
// ----------------------------------------------------------------------------
// The request channel carries one character and a line end flag per request.
// Characters are skipped until a sign, point or digit starts a number. The
// number ends when the configured count of fraction digits is complete, when
// any other character arrives, or at line end; it is then padded with zeros to
// the scale and sent on the response channel as a two's complement value
// with a flag for magnitudes clamped to the largest positive value.
// The csr channel writes the fraction digit count (values above four act as
// four) and is always ready; write it only while the parser is idle.
// One request is accepted every cycle while request ready is high. A
// response is registered in the output buffer. The path from the request
// to the response register is one multiplication of the magnitude by a
// power of ten plus an add and a compare.
// A two-entry output buffer lets one response wait while the next request
// is taken; request ready falls only when both entries are full.
// Reset is synchronous and sets the scale to two fraction digits, the
// parser to seeking a number and the output buffer to empty.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_text_to_fixed_point #(
   parameter int VALUE_BITS = 32
) (
   input  wire        clock,
   input  wire        reset,
   dtf_req_if.sink    req_if,
   dtf_rsp_if.source  rsp_if,
   dtf_csr_if.sink    csr_if
);
   import dtf_pkg::*;

`include "assert_macros.svh"

   localparam int MAG_W  = VALUE_BITS - 1;
   localparam int PAD_W  = 17;
   localparam int WIDE_W = MAG_W + PAD_W + 1;
   localparam int PUSH_W = MAG_W + 4;

   localparam logic [MAG_W-1:0]  MAG_LIMIT = {MAG_W{1'b1}};
   localparam logic [WIDE_W-1:0] POW10_1   = WIDE_W'(10);
   localparam logic [WIDE_W-1:0] POW10_2   = WIDE_W'(100);
   localparam logic [WIDE_W-1:0] POW10_3   = WIDE_W'(1000);
   localparam logic [WIDE_W-1:0] POW10_4   = WIDE_W'(10000);
   localparam logic [WIDE_W-1:0] POW10_5   = WIDE_W'(100000);

   typedef enum logic [2:0] {
      PH_SEEK   = 3'b001,
      PH_NUMBER = 3'b010,
      PH_SKIP   = 3'b100
   } phase_type;

   phase_type          phase_ff, phase_in, phase_mid;
   logic [FRAC_W-1:0]  frac_ff;
   logic [MAG_W-1:0]   acc_ff, acc_in;
   logic               neg_ff, pt_ff, ovf_ff;
   logic [FRAC_W-1:0]  fc_ff;

   logic                   out_valid_ff, skid_valid_ff;
   logic [VALUE_BITS-1:0]  out_value_ff, skid_value_ff;
   logic                   out_sat_ff, skid_sat_ff;

   logic                accept, is_digit, is_num, active, done, push, emit;
   logic [CHAR_W-1:0]   digit_full;
   logic [3:0]          digit;
   logic [FRAC_W-1:0]   scale;
   logic [MAG_W-1:0]    e_acc;
   logic                e_neg, e_pt, e_ovf;
   logic [FRAC_W-1:0]   e_fc;
   logic                post_neg, post_pt;
   logic [FRAC_W-1:0]   post_fc;
   logic [PUSH_W-1:0]   push_w;
   logic                push_ovf;
   logic [FRAC_W-1:0]   pad, expo;
   logic [WIDE_W-1:0]   e_acc_w, prod, wide;
   logic [PAD_W-1:0]    addend;
   logic                pad_ovf;
   logic [MAG_W-1:0]    mag;
   logic [VALUE_BITS-1:0] new_value;
   logic                new_sat;

   assign accept        = req_if.valid & req_if.ready;
   assign req_if.ready  = !skid_valid_ff;
   assign csr_if.ready  = 1'b1;
   assign rsp_if.valid  = out_valid_ff;
   assign rsp_if.value  = out_value_ff;
   assign rsp_if.saturated = out_sat_ff;

   assign scale      = (frac_ff > MAX_FRAC) ? MAX_FRAC : frac_ff;
   assign is_digit   = (req_if.char_in >= CHAR_ZERO) && (req_if.char_in <= CHAR_NINE);
   assign is_num     = is_digit || (req_if.char_in == CHAR_MINUS) ||
                       (req_if.char_in == CHAR_POINT);
   assign digit_full = req_if.char_in - CHAR_ZERO;
   assign digit      = digit_full[3:0];
   assign active     = is_num && (phase_ff != PH_SKIP);

   always_comb begin
      if (phase_ff == PH_NUMBER) begin
         e_acc = acc_ff;
         e_neg = neg_ff;
         e_pt  = pt_ff;
         e_fc  = fc_ff;
         e_ovf = ovf_ff;
      end else begin
         e_acc = '0;
         e_neg = 1'b0;
         e_pt  = 1'b0;
         e_fc  = '0;
         e_ovf = 1'b0;
      end
   end

   always_comb begin
      post_neg = e_neg;
      post_pt  = e_pt;
      post_fc  = e_fc;
      push     = 1'b0;
      done     = 1'b0;
      if (active) begin
         priority if (req_if.char_in == CHAR_MINUS) begin
            post_neg = !e_neg;
         end else if (req_if.char_in == CHAR_POINT) begin
            if (!e_pt) begin
               post_pt = 1'b1;
               post_fc = '0;
            end
            done = (post_fc >= scale);
         end else if (e_pt && (e_fc >= scale)) begin
            done = 1'b1;
         end else begin
            push = 1'b1;
            if (e_pt) begin
               post_fc = e_fc + 3'd1;
               done    = (post_fc >= scale);
            end
         end
      end
   end

   always_comb begin
      unique case (phase_ff)
         PH_NUMBER: phase_mid = is_num ? (done ? PH_SKIP : PH_NUMBER) : PH_SEEK;
         PH_SKIP:   phase_mid = is_num ? PH_SKIP : PH_SEEK;
         PH_SEEK:   phase_mid = is_num ? (done ? PH_SKIP : PH_NUMBER) : PH_SEEK;
         default:   phase_mid = PH_SEEK;
      endcase
      phase_in = req_if.line_end ? PH_SEEK : phase_mid;
      emit = ((phase_ff == PH_NUMBER) && !is_num) || (active && done) ||
             (req_if.line_end && (phase_mid == PH_NUMBER));
   end

   assign push_w   = {1'b0, e_acc, 3'b000} + {3'b000, e_acc, 1'b0} + PUSH_W'(digit);
   assign push_ovf = push_w > PUSH_W'(MAG_LIMIT);
   assign acc_in   = push ? (push_ovf ? MAG_LIMIT : push_w[MAG_W-1:0]) : e_acc;

   assign pad     = (scale > post_fc) ? (scale - post_fc) : '0;
   assign expo    = pad + FRAC_W'(push);
   assign e_acc_w = WIDE_W'(e_acc);

   always_comb begin
      unique case (expo)
         3'd0:    prod = e_acc_w;
         3'd1:    prod = e_acc_w * POW10_1;
         3'd2:    prod = e_acc_w * POW10_2;
         3'd3:    prod = e_acc_w * POW10_3;
         3'd4:    prod = e_acc_w * POW10_4;
         default: prod = e_acc_w * POW10_5;
      endcase
   end

   always_comb begin
      if (!push) begin
         addend = '0;
      end else begin
         unique case (pad)
            3'd0:    addend = PAD_W'(digit);
            3'd1:    addend = PAD_W'(digit) * PAD_W'(10);
            3'd2:    addend = PAD_W'(digit) * PAD_W'(100);
            3'd3:    addend = PAD_W'(digit) * PAD_W'(1000);
            default: addend = PAD_W'(digit) * PAD_W'(10000);
         endcase
      end
   end

   assign wide      = prod + WIDE_W'(addend);
   assign pad_ovf   = wide > WIDE_W'(MAG_LIMIT);
   assign mag       = pad_ovf ? MAG_LIMIT : wide[MAG_W-1:0];
   assign new_sat   = e_ovf | pad_ovf;
   assign new_value = post_neg ? (VALUE_BITS'(0) - {1'b0, mag}) : {1'b0, mag};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEEK;
         frac_ff  <= FRAC_RESET;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
         end
         if (csr_if.valid && csr_if.ready) begin
            frac_ff <= csr_if.frac_digits;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         acc_ff <= acc_in;
         neg_ff <= post_neg;
         pt_ff  <= post_pt;
         fc_ff  <= post_fc;
         ovf_ff <= e_ovf | (push & push_ovf);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_valid_ff && !rsp_if.ready) begin
         if (accept && emit) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (skid_valid_ff) begin
         out_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= accept & emit;
      end
   end

   always_ff @(posedge clock) begin
      if (out_valid_ff && !rsp_if.ready) begin
         if (accept && emit) begin
            skid_value_ff <= new_value;
            skid_sat_ff   <= new_sat;
         end
      end else if (skid_valid_ff) begin
         out_value_ff <= skid_value_ff;
         out_sat_ff   <= skid_sat_ff;
      end else begin
         out_value_ff <= new_value;
         out_sat_ff   <= new_sat;
      end
   end

   `ASSERT_ALWAYS(a_skid_behind_out, clock, reset, !skid_valid_ff || out_valid_ff, "skid entry without output entry")

   `ASSERT_IMPLIES(a_sat_at_limit, clock, reset, out_valid_ff && out_sat_ff, (out_value_ff == {1'b0, MAG_LIMIT}) || (out_value_ff == (VALUE_BITS'(0) - {1'b0, MAG_LIMIT})), "saturated response is not at the limit")

   `ASSERT_IMPLIES(a_frac_count_bound, clock, reset, phase_ff == PH_NUMBER, fc_ff <= MAX_FRAC, "fraction count beyond the largest scale")

   `ASSERT_IMPLIES(a_stall_holds, clock, reset, $past(out_valid_ff && !rsp_if.ready) && !$past(reset), out_valid_ff && $stable(out_value_ff), "stalled response changed")

endmodule

`default_nettype wire

// ----- tb/sv/tb_decimal_text_to_fixed_point.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal text to fixed-point parser testbench
// Streams characters into the parser and compares every returned number with
// an in-bench model. The run covers edge characters, signs, repeated points,
// saturation and fraction digit settings 0 to 5 and 7, then random text. Both
// channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_decimal_text_to_fixed_point;
   import dtf_pkg::*;

   localparam int VALUE_BITS = 32;
   localparam logic [63:0] MAG_LIMIT = (64'd1 << (VALUE_BITS - 1)) - 64'd1;
   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE_CYCLES = 4;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

   typedef enum logic [1:0] {SEEKING, IN_NUMBER, SKIPPING} parse_phase_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic                         saturated;
   } parsed_number_type;

   logic clock;
   logic reset;

   dtf_req_if                          req_if ();
   dtf_rsp_if #(.VALUE_BITS(VALUE_BITS)) rsp_if ();
   dtf_csr_if                          csr_if ();

   decimal_text_to_fixed_point #(
      .VALUE_BITS(VALUE_BITS)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   parsed_number_type pending_numbers[$];
   int unsigned       fault_count = 0;
   int unsigned       cycle_count = 0;
   int unsigned       number_chars;
   bit                calm;

   parse_phase_type   phase_m;
   logic [63:0]       magnitude_m;
   bit                negative_m;
   bit                point_m;
   bit                clamped_m;
   logic [2:0]        frac_count_m;
   logic [FRAC_W-1:0] scale_m;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_decimal_text_to_fixed_point NOT OK");
         $finish;
      end
   end

   function automatic bit is_number_char(input logic [CHAR_W-1:0] c);
      return c == CHAR_MINUS || c == CHAR_POINT || (c >= CHAR_ZERO && c <= CHAR_NINE);
   endfunction

   function automatic logic [FRAC_W-1:0] kept_digits();
      return (scale_m > MAX_FRAC) ? MAX_FRAC : scale_m;
   endfunction

   function automatic void push_digit(input logic [63:0] d);
      if (magnitude_m > (MAG_LIMIT - d) / 64'd10) begin
         magnitude_m = MAG_LIMIT;
         clamped_m   = 1'b1;
      end else begin
         magnitude_m = magnitude_m * 64'd10 + d;
      end
   endfunction

   function automatic void emit_number(output parsed_number_type r);
      logic [VALUE_BITS-1:0] mag;
      while (frac_count_m < kept_digits()) begin
         push_digit(64'd0);
         frac_count_m = frac_count_m + 3'd1;
      end
      mag         = magnitude_m[VALUE_BITS-1:0];
      r.value     = negative_m ? -mag : mag;
      r.saturated = clamped_m;
   endfunction

   function automatic bit absorb_char(input logic [CHAR_W-1:0] c);
      logic [FRAC_W-1:0] k;
      logic [63:0]       d;
      k = kept_digits();
      if (c == CHAR_MINUS) begin
         negative_m = !negative_m;
         return 1'b0;
      end
      if (c == CHAR_POINT) begin
         if (!point_m) begin
            point_m      = 1'b1;
            frac_count_m = 3'd0;
         end
         return frac_count_m >= k;
      end
      if (point_m && frac_count_m >= k) return 1'b1;
      d = 64'(c) - 64'(CHAR_ZERO);
      push_digit(d);
      if (point_m) begin
         frac_count_m = frac_count_m + 3'd1;
         return frac_count_m >= k;
      end
      return 1'b0;
   endfunction

   function automatic bit parse_char(input logic [CHAR_W-1:0] c, input bit le,
                                     output parsed_number_type r);
      bit num;
      bit got;
      num = is_number_char(c);
      got = 1'b0;
      case (phase_m)
         IN_NUMBER: begin
            if (!num) begin
               emit_number(r);
               got     = 1'b1;
               phase_m = SEEKING;
            end else if (absorb_char(c)) begin
               emit_number(r);
               got     = 1'b1;
               phase_m = SKIPPING;
            end
         end
         SKIPPING: begin
            if (!num) phase_m = SEEKING;
         end
         default: begin
            phase_m = SEEKING;
            if (num) begin
               magnitude_m  = 64'd0;
               negative_m   = 1'b0;
               point_m      = 1'b0;
               frac_count_m = 3'd0;
               clamped_m    = 1'b0;
               phase_m      = IN_NUMBER;
               if (absorb_char(c)) begin
                  emit_number(r);
                  got     = 1'b1;
                  phase_m = SKIPPING;
               end
            end
         end
      endcase
      if (le) begin
         if (phase_m == IN_NUMBER) begin
            emit_number(r);
            got = 1'b1;
         end
         phase_m = SEEKING;
      end
      return got;
   endfunction

   initial begin
      parsed_number_type want;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (pending_numbers.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("unexpected number: value=%0d saturated=%0b",
                           rsp_if.value, rsp_if.saturated);
            end else begin
               want = pending_numbers.pop_front();
               if (rsp_if.value !== want.value || rsp_if.saturated !== want.saturated) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display("mismatch: expected value=%0d saturated=%0b, got value=%0d saturated=%0b",
                              want.value, want.saturated, rsp_if.value, rsp_if.saturated);
               end
            end
         end
         rsp_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 35);
      end
   end

   task automatic send_char(input logic [CHAR_W-1:0] c, input bit le);
      parsed_number_type r;
      int unsigned       gap;
      gap = 0;
      if (!calm) begin
         while ($urandom_range(99) < 35) gap++;
      end
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.char_in  <= c;
      req_if.line_end <= le;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      if (parse_char(c, le, r)) pending_numbers.push_back(r);
      if (is_number_char(c)) number_chars++;
   endtask

   task automatic send_text(input string s, input bit le_last);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], le_last && i == s.len() - 1);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (pending_numbers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_scale(input logic [FRAC_W-1:0] digits);
      if (phase_m != SEEKING) send_char(CHAR_SPACE, 1'b1);
      drain();
      csr_if.valid       <= 1'b1;
      csr_if.frac_digits <= digits;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      csr_if.valid <= 1'b0;
      scale_m = digits;
   endtask

   task automatic send_random_number();
      logic [CHAR_W-1:0] text[$];
      logic [CHAR_W-1:0] term;
      int unsigned       roll;
      int unsigned       digits;
      roll = $urandom_range(99);
      if (roll < 25) text.push_back(CHAR_MINUS);
      if (roll < 4) text.push_back(CHAR_MINUS);
      roll = $urandom_range(99);
      if (roll < 5) digits = 0;
      else if (roll < 90) digits = $urandom_range(5, 1);
      else digits = $urandom_range(14, 8);
      repeat (digits) text.push_back(CHAR_ZERO + CHAR_W'($urandom_range(9)));
      if ($urandom_range(99) < 70) begin
         text.push_back(CHAR_POINT);
         if ($urandom_range(99) < 5) text.push_back(CHAR_POINT);
         repeat ($urandom_range(6)) text.push_back(CHAR_ZERO + CHAR_W'($urandom_range(9)));
      end
      if (text.size() == 0) text.push_back(CHAR_ZERO + CHAR_W'($urandom_range(9)));
      roll = $urandom_range(99);
      for (int i = 0; i < text.size(); i++)
         send_char(text[i], roll < 25 && i == text.size() - 1);
      if (roll >= 25) begin
         do term = CHAR_W'($urandom_range(255)); while (is_number_char(term));
         send_char(term, roll < 35);
      end
   endtask

   task automatic send_noise();
      repeat ($urandom_range(4, 1))
         send_char(CHAR_W'($urandom_range(255)), $urandom_range(9) == 0);
   endtask

   task automatic test_directed();
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b0);
      send_text("-1.5,", 1'b0);
      send_text("7.891x", 1'b0);
      send_text("..5 ", 1'b0);
      send_text("--3;", 1'b0);
      send_text("- ", 1'b0);
      send_text("6a7 ", 1'b0);
      send_text("4", 1'b1);
   endtask

   task automatic test_saturation();
      send_text("21474836.47,", 1'b0);
      send_text("-21474836.48", 1'b1);
      send_text("99999999999 ", 1'b0);
   endtask

   task automatic test_scales();
      logic [FRAC_W-1:0] settings[5] = '{3'd0, 3'd1, 3'd3, 3'd5, 3'd7};
      foreach (settings[i]) begin
         write_scale(settings[i]);
         send_text("3.7,", 1'b0);
         send_text("-.0625", 1'b1);
         repeat (2) send_random_number();
      end
   endtask

   task automatic test_random();
      int unsigned start;
      int unsigned stage;
      start = number_chars;
      stage = 0;
      calm  = 1'b1;
      write_scale(3'd2);
      while (number_chars - start < 210) begin
         if (stage == 0 && number_chars - start >= 70) begin
            stage = 1;
            calm  = 1'b0;
            write_scale(3'd0);
         end else if (stage == 1 && number_chars - start >= 140) begin
            stage = 2;
            write_scale(3'd4);
         end
         if ($urandom_range(99) < 85) send_random_number();
         else send_noise();
      end
   endtask

   initial begin
      calm         = 1'b1;
      number_chars = 0;
      phase_m      = SEEKING;
      magnitude_m  = 64'd0;
      negative_m   = 1'b0;
      point_m      = 1'b0;
      clamped_m    = 1'b0;
      frac_count_m = 3'd0;
      scale_m      = FRAC_RESET;
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.char_in     <= '0;
      req_if.line_end    <= 1'b0;
      csr_if.valid       <= 1'b0;
      csr_if.frac_digits <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      calm = 1'b0;
      test_directed();
      test_saturation();
      test_scales();
      test_random();

      drain();
      repeat (10) @(posedge clock);
      if (fault_count == 0 && pending_numbers.size() == 0) begin
         $display("tb_decimal_text_to_fixed_point OK");
      end else begin
         $display("tb_decimal_text_to_fixed_point NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
